// ----- sv/nmf_pkg.sv -----
// ----------------------------------------------------------------------------
// nmf_pkg
// shared widths, register indexes and the ring entry layout of the
// minimum-delay clock offset filter
// ----------------------------------------------------------------------------
package nmf_pkg;

  localparam int TIME_W    = 64;
  localparam int DELAY_W   = 32;
  localparam int OFS_W     = 63;
  localparam int MID_W     = 61;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W   = DELAY_W + OFS_W + MID_W;

  // sum of up to sixteen offsets
  localparam int SUM_W     = OFS_W + 4;

  // serial multiplier: 68 x 68 bits, one 17-bit digit per cycle
  localparam int MUL_W     = 68;
  localparam int MUL_DIG   = 17;
  localparam int MUL_STEPS = 4;
  localparam int PROD_W    = 2 * MUL_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RTT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_LIMIT = 2'd1;

  localparam logic [CFG_W-1:0] MAX_RTT_RST      = 32'd60000000;
  localparam logic [CFG_W-1:0] STABLE_LIMIT_RST = 32'd60000;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [OFS_W-1:0]   offset;
    logic [MID_W-1:0]   mid;
  } entry_t;

endpackage

// ----- sv/nmf_ram.sv -----
// ----------------------------------------------------------------------------
// nmf_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module nmf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/nmf_mul.sv -----
// ----------------------------------------------------------------------------
// nmf_mul
// digit-serial unsigned multiplier, most significant digit of b first
// ----------------------------------------------------------------------------
module nmf_mul import nmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int SW = $clog2(MUL_STEPS);

  logic [MUL_W-1:0]         a_r;
  logic [MUL_W-1:0]         b_r;
  logic [PROD_W-1:0]        acc;
  logic [SW-1:0]            step;
  logic                     run;
  logic [MUL_DIG-1:0]       digit;
  logic [MUL_W+MUL_DIG-1:0] part;

  assign digit = b_r[MUL_W-1 -: MUL_DIG];
  assign part  = a_r * digit;
  assign prod  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == SW'(MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (run) begin
      acc <= (acc << MUL_DIG) + PROD_W'(part);
      b_r <= b_r << MUL_DIG;
    end
  end

endmodule

// ----- sv/ntp_min_rtt_offset_filter_top.sv -----
// ----------------------------------------------------------------------------
// ntp_min_rtt_offset_filter_top
// minimum-delay clock offset filter over a ring of timestamp samples
// ----------------------------------------------------------------------------
// word time: set by the ring scan through one ram read port and the serial
//   squaring unit
// throughput: one word at a time; the next word is taken once the result
//   is registered, while that result still waits at the output
// reset: synchronous, registers to defaults, ring empty, chosen best delay all ones
module ntp_min_rtt_offset_filter_top import nmf_pkg::*; #(
  parameter int RING_DEPTH   = 16,
  parameter int RECENT_COUNT = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [TIME_W-1:0]              time_sent,
  input  logic signed [TIME_W-1:0]              time_peer_recv,
  input  logic signed [TIME_W-1:0]              time_peer_sent,
  input  logic signed [TIME_W-1:0]              time_recv,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  accepted,
  output logic [DELAY_W-1:0]                    sample_delay,
  output logic signed [OFS_W-1:0]               sample_offset,
  output logic [MID_W-1:0]                      sample_midpoint,
  output logic [DELAY_W-1:0]                    best_delay,
  output logic signed [OFS_W-1:0]               best_offset,
  output logic [$clog2(RING_DEPTH+1)-1:0]       held_count,
  output logic                                  stable
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int JW = $clog2(RECENT_COUNT);
  localparam logic [AW:0] BACK  = (AW+1)'(RING_DEPTH - (RECENT_COUNT % RING_DEPTH));
  localparam logic [AW:0] DEPTH = (AW+1)'(RING_DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CALC     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_PICK     = 4'd4;
  localparam logic [3:0] S_ST0      = 4'd5;
  localparam logic [3:0] S_ST_RD    = 4'd6;
  localparam logic [3:0] S_ST_WAIT  = 4'd7;
  localparam logic [3:0] S_ST_MUL   = 4'd8;
  localparam logic [3:0] S_SS       = 4'd9;
  localparam logic [3:0] S_SS_MUL   = 4'd10;
  localparam logic [3:0] S_CMP      = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0]               state;
  logic [CFG_W-1:0]         max_rtt;
  logic [CFG_W-1:0]         stable_limit;
  logic signed [TIME_W-1:0] t1, t2, t3, t4;
  logic [AW-1:0]            slot;
  logic [CW-1:0]            cnt;
  logic [DELAY_W-1:0]       chosen_delay;
  logic [OFS_W-1:0]         chosen_offset;
  logic                     s_ok;
  logic [DELAY_W-1:0]       s_delay;
  logic [OFS_W-1:0]         s_offset;
  logic [MID_W-1:0]         s_mid;
  logic [AW-1:0]            k;
  logic [JW-1:0]            j;
  logic                     dv;
  logic                     dfirst;
  logic [DELAY_W-1:0]       best_d;
  logic [MID_W-1:0]         best_m;
  logic [OFS_W-1:0]         best_o;
  logic [SUM_W-1:0]         sum;
  logic [PROD_W-1:0]        q;
  logic [PROD_W-1:0]        s2;
  logic [PROD_W-1:0]        nq;
  logic [PROD_W-1:0]        r;
  logic [2*CFG_W-1:0]       lim2;
  logic                     stab;

  // sample arithmetic
  logic signed [TIME_W-1:0] d41, d32, dly, ofs_sum, ofs_half, mid;
  logic                     range_ok;
  logic                     ok;

  assign d41      = t4 - t1;
  assign d32      = t3 - t2;
  assign dly      = d41 - d32;
  assign ofs_sum  = (t2 - t1) + (t3 - t4);
  assign ofs_half = (ofs_sum + $signed({{(TIME_W-1){1'b0}}, ofs_sum[TIME_W-1]})) >>> 1;
  assign mid      = t1 + (d41 >>> 1);
  assign range_ok = (t1[TIME_W-1 -: 3] == 3'b000) && (t2[TIME_W-1 -: 3] == 3'b000) &&
                    (t3[TIME_W-1 -: 3] == 3'b000) && (t4[TIME_W-1 -: 3] == 3'b000);
  assign ok       = range_ok && !dly[TIME_W-1] && ($unsigned(dly) <= TIME_W'(max_rtt)) &&
                    !d41[TIME_W-1] && !d32[TIME_W-1];

  // ring
  logic          ram_we;
  logic          ram_re;
  entry_t        wentry;
  logic [ENTRY_W-1:0] rword;
  entry_t        rentry;

  assign ram_we = (state == S_CALC) && ok;
  assign ram_re = (state == S_SCAN) || (state == S_ST_RD);
  assign wentry = '{delay: dly[DELAY_W-1:0], offset: ofs_half[OFS_W-1:0], mid: mid[MID_W-1:0]};
  assign rentry = entry_t'(rword);

  nmf_ram #(.W(ENTRY_W), .D(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wentry),
    .re    (ram_re),
    .raddr (k),
    .rdata (rword)
  );

  // address helpers
  logic [AW:0]   st_tmp;
  logic [AW-1:0] st_start;
  logic [AW-1:0] k_inc;
  logic [AW-1:0] slot_inc;

  assign st_tmp   = {1'b0, slot} + BACK;
  assign st_start = (st_tmp >= DEPTH) ? AW'(st_tmp - DEPTH) : st_tmp[AW-1:0];
  assign k_inc    = (k == AW'(RING_DEPTH - 1)) ? '0 : k + 1'b1;
  assign slot_inc = (slot == AW'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;

  // squaring unit
  logic              mul_start;
  logic [MUL_W-1:0]  mul_op;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic [OFS_W-1:0]  xmag;
  logic [SUM_W-1:0]  smag;

  assign xmag      = rentry.offset[OFS_W-1] ? (~rentry.offset + 1'b1) : rentry.offset;
  assign smag      = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  assign mul_start = (state == S_ST_WAIT) || (state == S_SS);
  assign mul_op    = (state == S_SS) ? MUL_W'(smag) : MUL_W'(xmag);

  nmf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_op),
    .b     (mul_op),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_rtt       <= MAX_RTT_RST;
      stable_limit  <= STABLE_LIMIT_RST;
      slot          <= '0;
      cnt           <= '0;
      chosen_delay  <= '1;
      chosen_offset <= '0;
      out_valid     <= 1'b0;
      dv            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_RTT:      max_rtt <= cfg_data;
          REG_STABLE_LIMIT: stable_limit <= cfg_data;
          default: ;
        endcase
      end

      dv <= (state == S_SCAN);

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (ok) begin
            slot  <= slot_inc;
            if (cnt != CW'(RING_DEPTH)) begin
              cnt <= cnt + 1'b1;
            end
            k     <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_ST0;
          end
        end
        S_SCAN: begin
          k <= k + 1'b1;
          if (CW'(k) == cnt - 1'b1) begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_END: state <= S_PICK;
        S_PICK: begin
          chosen_delay  <= best_d;
          chosen_offset <= best_o;
          state         <= S_ST0;
        end
        S_ST0: begin
          k <= st_start;
          j <= '0;
          if (32'(cnt) < 32'(RECENT_COUNT)) begin
            state <= S_DONE;
          end else begin
            state <= S_ST_RD;
          end
        end
        S_ST_RD:   state <= S_ST_WAIT;
        S_ST_WAIT: begin
          k     <= k_inc;
          state <= S_ST_MUL;
        end
        S_ST_MUL: begin
          if (mul_done) begin
            if (j == JW'(RECENT_COUNT - 1)) begin
              state <= S_SS;
            end else begin
              j     <= j + 1'b1;
              state <= S_ST_RD;
            end
          end
        end
        S_SS: state <= S_SS_MUL;
        S_SS_MUL: begin
          if (mul_done) begin
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      t1 <= time_sent;
      t2 <= time_peer_recv;
      t3 <= time_peer_sent;
      t4 <= time_recv;
    end

    if (state == S_CALC) begin
      s_ok     <= ok;
      s_delay  <= ok ? dly[DELAY_W-1:0] : '0;
      s_offset <= ok ? ofs_half[OFS_W-1:0] : '0;
      s_mid    <= ok ? mid[MID_W-1:0] : '0;
    end

    if (state == S_SCAN) begin
      dfirst <= (k == '0);
    end

    if (dv) begin
      if (dfirst || (rentry.delay < best_d) ||
          ((rentry.delay == best_d) && (rentry.mid > best_m))) begin
        best_d <= rentry.delay;
        best_m <= rentry.mid;
        best_o <= rentry.offset;
      end
    end

    if (state == S_ST0) begin
      sum  <= '0;
      q    <= '0;
      stab <= 1'b0;
    end

    if (state == S_ST_WAIT) begin
      sum <= sum + {{(SUM_W-OFS_W){rentry.offset[OFS_W-1]}}, rentry.offset};
    end

    if (state == S_ST_MUL && mul_done) begin
      q <= q + mul_prod;
    end

    if (state == S_SS) begin
      lim2 <= stable_limit * stable_limit;
    end

    if (state == S_SS_MUL && mul_done) begin
      s2 <= mul_prod;
      r  <= PROD_W'(lim2) * PROD_W'(RECENT_COUNT * (RECENT_COUNT - 1));
      nq <= q * PROD_W'(RECENT_COUNT);
    end

    if (state == S_CMP) begin
      stab <= (nq < s2 + r);
    end

    if (out_load) begin
      accepted        <= s_ok;
      sample_delay    <= s_delay;
      sample_offset   <= $signed(s_offset);
      sample_midpoint <= s_mid;
      best_delay      <= chosen_delay;
      best_offset     <= $signed(chosen_offset);
      held_count      <= cnt;
      stable          <= stab;
    end
  end

endmodule

// ----- sv/nmf_check.sv -----
// ----------------------------------------------------------------------------
// nmf_check
// port-level checks for the minimum-delay clock offset filter
// ----------------------------------------------------------------------------
module nmf_check import nmf_pkg::*; #(
  parameter int HW = 5
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     accepted,
  input logic [DELAY_W-1:0]       sample_delay,
  input logic signed [OFS_W-1:0]  sample_offset,
  input logic [MID_W-1:0]         sample_midpoint,
  input logic [DELAY_W-1:0]       best_delay,
  input logic signed [OFS_W-1:0]  best_offset,
  input logic [HW-1:0]            held_count,
  input logic                     stable
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_offset) && $stable(sample_offset))
    else $error("result word changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> sample_delay == '0 && sample_offset == '0 &&
                               sample_midpoint == '0)
    else $error("rejected sample carries nonzero fields");

  a_best_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> best_delay <= sample_delay && held_count != '0)
    else $error("best delay above stored sample delay");

  a_few_unstable: assert property (@(posedge clk) disable iff (rst)
    out_valid && held_count <= HW'(1) |-> !stable)
    else $error("stable flagged with too few samples");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

endmodule

bind ntp_min_rtt_offset_filter_top nmf_check #(.HW(CW)) u_nmf_check (.*);
